// ===== src/tpm_pkg.sv =====
// Package for the track pair matcher: widths, latencies and the arctangent table.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tpm_pkg;

    // Field widths and fixed-point formats.
    localparam int COORD_WIDTH     = 20;
    localparam int ANGLE_FRAC_BITS = 14;
    localparam int CORDIC_STEPS    = 16;

    localparam int OLIM_W = 19;
    localparam int ALIM_W = 15;

    // Track deltas and the products formed from them.
    localparam int DELTA_W = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DELTA_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int LEN_W   = COORD_WIDTH;
    localparam int LP_W    = 2 * LEN_W;

    // Extrapolation divider: quotient bits, position and offset widths.
    localparam int DIV_N_W = 2 * COORD_WIDTH + 1;
    localparam int PAT_W   = DIV_N_W + 2;
    localparam int OFF_W   = PAT_W + 1;
    localparam int DIV_LAT = DIV_N_W + 2;

    // Arctangent by rotation steps.
    localparam int PRESCALE_BITS = 20;
    localparam int TABLE_FRAC    = 30;
    localparam int CX_W          = DELTA_W + PRESCALE_BITS + 2;
    localparam int CZ_W          = TABLE_FRAC + 2;
    localparam int ANG_SH        = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam int ANG_W         = CZ_W - ANG_SH;
    localparam int ANGD_W        = ANG_W + 1;
    localparam int CORDIC_LAT    = CORDIC_STEPS + 2;

    // Square root of the summed squares.
    localparam int SQ_STEPS = COORD_WIDTH + 1;
    localparam int SQ_IN_W  = 2 * SQ_STEPS;
    localparam int SQ_REM_W = SQ_STEPS + 3;
    localparam int SQRT_LAT = SQ_STEPS + 2;
    localparam logic [COORD_WIDTH-1:0] RES_MAX = '1;

    // Cosine division.
    localparam int COS_FRAC = 14;
    localparam int COS_W    = 16;
    localparam int COS_Q_W  = COS_FRAC + 1;
    localparam int COS_ONE  = 1 << COS_FRAC;
    localparam int CN_W     = 2 * COORD_WIDTH + 3 + COS_FRAC;
    localparam int COS_LAT  = COS_Q_W + 3;

    // round(atan(2^-i) * 2^30)
    localparam int ATAN_TAB [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

endpackage

`default_nettype wire

// ===== src/tpm_extrap_div.sv =====
// Pipelined restoring divider that places a track coordinate on the plane:
// base + round(num / dz), rounded half away from zero. Depends on tpm_pkg.
`default_nettype none

module tpm_extrap_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [tpm_pkg::PROD_W-1:0]  i_num,
    input  wire logic signed [tpm_pkg::DELTA_W-1:0] i_dz,
    input  wire logic signed [tpm_pkg::COORD_WIDTH-1:0] i_base,
    output logic signed [tpm_pkg::PAT_W-1:0]        o_pos
);
    import tpm_pkg::*;

    localparam int N = DIV_N_W;
    localparam int R = DELTA_W;

    logic [PROD_W-1:0]  w_nabs;
    logic [R-1:0]       w_ud;
    logic [N-1:0]       w_np;

    logic [N-1:0]               r_np   [N+1];
    logic [R-1:0]               r_ud   [N+1];
    logic                       r_neg  [N+1];
    logic signed [COORD_WIDTH-1:0] r_base [N+1];
    logic [R-1:0]               r_rem  [N+1];
    logic [N-1:0]               r_quo  [N+1];

    logic signed [PAT_W-1:0] w_q;
    logic signed [PAT_W-1:0] w_sq;

    // Magnitudes and the half-divisor bias for rounding.
    always_comb begin
        w_nabs = i_num[PROD_W-1] ? PROD_W'(-i_num) : PROD_W'(i_num);
        w_ud   = i_dz[R-1] ? R'(-i_dz) : R'(i_dz);
        w_np   = N'(w_nabs) + N'(w_ud >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_np[0]   <= w_np;
            r_ud[0]   <= w_ud;
            r_neg[0]  <= i_num[PROD_W-1] ^ i_dz[R-1];
            r_base[0] <= i_base;
            r_rem[0]  <= '0;
            r_quo[0]  <= '0;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [R:0]   w_trial;
        logic         w_ge;
        logic [R-1:0] w_rem;

        always_comb begin
            w_trial = {r_rem[k-1], r_np[k-1][N-k]};
            w_ge    = w_trial >= {1'b0, r_ud[k-1]};
            w_rem   = w_ge ? R'(w_trial - {1'b0, r_ud[k-1]}) : w_trial[R-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_np[k]   <= r_np[k-1];
                r_ud[k]   <= r_ud[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_base[k] <= r_base[k-1];
                r_rem[k]  <= w_rem;
                r_quo[k]  <= {r_quo[k-1][N-2:0], w_ge};
            end
        end
    end

    // Apply the sign and add the start coordinate.
    always_comb begin
        w_q  = PAT_W'(r_quo[N]);
        w_sq = r_neg[N] ? -w_q : w_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pos <= PAT_W'(r_base[N]) + w_sq;
        end
    end

endmodule

`default_nettype wire

// ===== src/tpm_atan.sv =====
// Pipelined vectoring rotations giving atan(num / den) in 2^-ANGLE_FRAC_BITS rad.
// One rotation per stage; depends on tpm_pkg for widths and the angle table.
`default_nettype none

module tpm_atan (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [tpm_pkg::DELTA_W-1:0] i_num,
    input  wire logic signed [tpm_pkg::DELTA_W-1:0] i_den,
    output logic signed [tpm_pkg::ANG_W-1:0]        o_angle
);
    import tpm_pkg::*;

    localparam int S = CORDIC_STEPS;

    logic [DELTA_W-1:0]        w_dabs;
    logic signed [DELTA_W-1:0] w_ny;
    logic signed [CZ_W-1:0]    w_zr;

    logic signed [CX_W-1:0] r_x [S+1];
    logic signed [CX_W-1:0] r_y [S+1];
    logic signed [CZ_W-1:0] r_z [S+1];

    // Fold the vector into the right half plane and prescale it.
    always_comb begin
        w_dabs = i_den[DELTA_W-1] ? DELTA_W'(-i_den) : DELTA_W'(i_den);
        w_ny   = i_den[DELTA_W-1] ? -i_num : i_num;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CX_W'(w_dabs) << PRESCALE_BITS;
            r_y[0] <= CX_W'(w_ny) <<< PRESCALE_BITS;
            r_z[0] <= '0;
        end
    end

    // Each stage rotates towards the x axis and accumulates the angle.
    for (genvar k = 1; k <= S; k++) begin : g_rot
        logic signed [CX_W-1:0] w_xs;
        logic signed [CX_W-1:0] w_ys;

        always_comb begin
            w_xs = r_x[k-1] >>> (k - 1);
            w_ys = r_y[k-1] >>> (k - 1);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[k-1][CX_W-1]) begin
                    r_x[k] <= r_x[k-1] + w_ys;
                    r_y[k] <= r_y[k-1] - w_xs;
                    r_z[k] <= r_z[k-1] + CZ_W'(ATAN_TAB[k-1]);
                end else begin
                    r_x[k] <= r_x[k-1] - w_ys;
                    r_y[k] <= r_y[k-1] + w_xs;
                    r_z[k] <= r_z[k-1] - CZ_W'(ATAN_TAB[k-1]);
                end
            end
        end
    end

    // Round half up to the output angle unit.
    always_comb begin
        w_zr = r_z[S] + CZ_W'(1 << (ANG_SH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= ANG_W'(w_zr >>> ANG_SH);
        end
    end

endmodule

`default_nettype wire

// ===== src/tpm_sqrt.sv =====
// Pipelined digit-by-digit square root, rounded to nearest and saturated to
// the residual range. Depends on tpm_pkg.
`default_nettype none

module tpm_sqrt (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [tpm_pkg::SQ_IN_W-1:0]       i_val,
    input  wire logic                              i_sat,
    output logic [tpm_pkg::COORD_WIDTH-1:0]        o_root
);
    import tpm_pkg::*;

    localparam int S = SQ_STEPS;

    logic [SQ_IN_W-1:0]  r_val  [S+1];
    logic [SQ_REM_W-1:0] r_rem  [S+1];
    logic [S-1:0]        r_root [S+1];
    logic                r_sat  [S+1];

    logic                w_up;
    logic [S:0]          w_rnd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val[0]  <= i_val;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_sat[0]  <= i_sat;
        end
    end

    // Two radicand bits and one root bit per stage.
    for (genvar k = 1; k <= S; k++) begin : g_digit
        logic [SQ_REM_W-1:0] w_tr;
        logic [SQ_REM_W-1:0] w_trial;
        logic                w_ge;

        always_comb begin
            w_tr    = {r_rem[k-1][SQ_REM_W-3:0], r_val[k-1][SQ_IN_W-2*k+1 -: 2]};
            w_trial = SQ_REM_W'({r_root[k-1], 2'b01});
            w_ge    = w_tr >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[k]  <= r_val[k-1];
                r_sat[k]  <= r_sat[k-1];
                r_rem[k]  <= w_ge ? w_tr - w_trial : w_tr;
                r_root[k] <= {r_root[k-1][S-2:0], w_ge};
            end
        end
    end

    // Round up when the remainder exceeds the root, then saturate.
    always_comb begin
        w_up  = r_rem[S] > SQ_REM_W'(r_root[S]);
        w_rnd = (S+1)'(r_root[S]) + (S+1)'(w_up);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sat[S] || w_rnd > (S+1)'(RES_MAX)) begin
                o_root <= RES_MAX;
            end else begin
                o_root <= w_rnd[COORD_WIDTH-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tpm_cos_div.sv =====
// Pipelined divider for the cosine: round(dot * 2^14 / (len_ref * len_cand)),
// half away from zero, saturated at one. Depends on tpm_pkg.
`default_nettype none

module tpm_cos_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic signed [tpm_pkg::DOT_W-1:0] i_dot,
    input  wire logic [tpm_pkg::LP_W-1:0]         i_lp,
    output logic signed [tpm_pkg::COS_W-1:0]      o_cos
);
    import tpm_pkg::*;

    localparam int Q = COS_Q_W;

    logic [DOT_W-1:0] w_mag;
    logic [CN_W-1:0]  w_np;
    logic [CN_W-1:0]  w_hi;

    logic [CN_W-1:0]  r_np;
    logic [LP_W-1:0]  r_ud_a;
    logic             r_neg_a;

    logic [LP_W-1:0]  r_ud  [Q+1];
    logic [LP_W-1:0]  r_rem [Q+1];
    logic [Q-1:0]     r_low [Q+1];
    logic [Q-1:0]     r_quo [Q+1];
    logic             r_ovf [Q+1];
    logic             r_neg [Q+1];

    logic [Q-1:0]            w_q;
    logic signed [COS_W-1:0] w_qs;

    // Magnitude of the scaled dot product with the rounding bias.
    always_comb begin
        w_mag = i_dot[DOT_W-1] ? DOT_W'(-i_dot) : DOT_W'(i_dot);
        w_np  = (CN_W'(w_mag) << COS_FRAC) + CN_W'(i_lp >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_np    <= w_np;
            r_ud_a  <= i_lp;
            r_neg_a <= i_dot[DOT_W-1];
        end
    end

    // A quotient of 2^Q or more is saturated outright; otherwise the high part
    // is already a valid partial remainder.
    always_comb begin
        w_hi = r_np >> Q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= w_hi >= CN_W'(r_ud_a);
            r_rem[0] <= w_hi[LP_W-1:0];
            r_low[0] <= r_np[Q-1:0];
            r_ud[0]  <= r_ud_a;
            r_neg[0] <= r_neg_a;
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 1; k <= Q; k++) begin : g_step
        logic [LP_W:0]   w_trial;
        logic            w_ge;

        always_comb begin
            w_trial = {r_rem[k-1], r_low[k-1][Q-k]};
            w_ge    = w_trial >= {1'b0, r_ud[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? LP_W'(w_trial - {1'b0, r_ud[k-1]}) : w_trial[LP_W-1:0];
                r_quo[k] <= {r_quo[k-1][Q-2:0], w_ge};
                r_low[k] <= r_low[k-1];
                r_ud[k]  <= r_ud[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    // Clamp to one and restore the sign.
    always_comb begin
        if (r_ovf[Q] || r_quo[Q] > Q'(COS_ONE)) begin
            w_q = Q'(COS_ONE);
        end else begin
            w_q = r_quo[Q];
        end
        w_qs = COS_W'(w_q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_neg[Q] ? -w_qs : w_qs;
        end
    end

endmodule

`default_nettype wire

// ===== src/track_pair_match_cut_top.sv =====
// Top level of the track pair matcher: register port, reference store, front
// stages, offset and residual path, delay lines. Uses tpm_pkg and all tpm_ units.
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  input    | i_valid, o_stall, i_opcode, i_start_*,    | in
//           | i_end_*, i_track_length                   |
//  output   | o_valid, i_stall, o_matched, o_residual,  | out
//           | o_cos_angle, o_degenerate                 |
//  config   | psel, penable, pwrite, paddr, pwdata,     | APB
//           | prdata, pready                            |
//
// One item is accepted per cycle while the output is not stalled. The depth of a
// test item's path is set by the extrapolation dividers, one quotient bit per stage,
// and the square root.
// Load items update the reference at once and produce no result.
// Reset clears the registers, the reference and all valid bits.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
`default_nettype none

module track_pair_match_cut_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Input channel
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic                                   i_opcode,
    input  wire logic signed [tpm_pkg::COORD_WIDTH-1:0] i_start_x,
    input  wire logic signed [tpm_pkg::COORD_WIDTH-1:0] i_start_y,
    input  wire logic signed [tpm_pkg::COORD_WIDTH-1:0] i_start_z,
    input  wire logic signed [tpm_pkg::COORD_WIDTH-1:0] i_end_x,
    input  wire logic signed [tpm_pkg::COORD_WIDTH-1:0] i_end_y,
    input  wire logic signed [tpm_pkg::COORD_WIDTH-1:0] i_end_z,
    input  wire logic [tpm_pkg::COORD_WIDTH-1:0]        i_track_length,
    // Output channel
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic                                        o_matched,
    output logic [tpm_pkg::COORD_WIDTH-1:0]             o_residual,
    output logic signed [tpm_pkg::COS_W-1:0]            o_cos_angle,
    output logic                                        o_degenerate,
    // Register port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [4:0]                             paddr,
    input  wire logic [31:0]                            pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);
    import tpm_pkg::*;

    typedef enum logic [2:0] {
        REG_EXTRAP_Z = 3'd0,
        REG_X_OFF    = 3'd1,
        REG_Y_OFF    = 3'd2,
        REG_Y_ANG    = 3'd3,
        REG_X_ANG    = 3'd4
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } t_opcode;

    // Pipeline positions, counted in registers after acceptance.
    localparam int T_DIV = 2 + DIV_LAT;
    localparam int T_RES = T_DIV + 4 + SQRT_LAT;
    localparam int T_ANG = 1 + CORDIC_LAT + 1;
    localparam int T_COS = 3 + COS_LAT;
    localparam int D_ANG = T_RES - T_ANG;
    localparam int D_OFF = T_RES - (T_DIV + 3);
    localparam int D_DEG = T_RES - 1;
    localparam int D_COS = T_RES - T_COS;

    logic en;
    logic accept;
    logic cfg_wr;
    t_reg_idx cfg_idx;

    // Configuration and reference registers.
    logic signed [COORD_WIDTH-1:0] r_ext_z;
    logic [OLIM_W-1:0]             r_xoff;
    logic [OLIM_W-1:0]             r_yoff;
    logic [ALIM_W-1:0]             r_yang;
    logic [ALIM_W-1:0]             r_xang;
    logic signed [COORD_WIDTH-1:0] r_ref_sx, r_ref_sy, r_ref_sz;
    logic signed [COORD_WIDTH-1:0] r_ref_ex, r_ref_ey, r_ref_ez;
    logic [LEN_W-1:0]              r_ref_len;

    logic [T_RES-1:0] r_vld;
    logic             r_out_valid;

    // Stage 1: deltas and distances to the plane.
    logic signed [DELTA_W-1:0] r1_drx, r1_dry, r1_drz, r1_dcx, r1_dcy, r1_dcz;
    logic signed [DELTA_W-1:0] r1_ezr, r1_ezc;
    logic signed [COORD_WIDTH-1:0] r1_rsx, r1_rsy, r1_csx, r1_csy;
    logic [LEN_W-1:0]          r1_lr, r1_lc;
    logic                      r1_zdz, r1_zlen;

    // Stage 2: products.
    logic signed [PROD_W-1:0]  r2_nrx, r2_nry, r2_ncx, r2_ncy;
    logic signed [PROD_W-1:0]  r2_p0, r2_p1, r2_p2;
    logic [LP_W-1:0]           r2_lp;
    logic signed [DELTA_W-1:0] r2_dzr, r2_dzc;
    logic signed [COORD_WIDTH-1:0] r2_rsx, r2_rsy, r2_csx, r2_csy;

    // Stage 3: dot product.
    logic signed [DOT_W-1:0]   r3_dot;
    logic [LP_W-1:0]           r3_lp;

    // Unit outputs.
    logic signed [PAT_W-1:0]   w_prx, w_pry, w_pcx, w_pcy;
    logic signed [ANG_W-1:0]   w_arx, w_ary, w_acx, w_acy;
    logic signed [COS_W-1:0]   w_cos;
    logic [COORD_WIDTH-1:0]    w_root;

    // Offset path.
    logic signed [OFF_W-1:0]   r_ox, r_oy;
    logic [OFF_W-1:0]          r_ax, r_ay;
    logic                      r_sat2, r_sat3, r_sat4;
    logic [1:0]                r_off_ok;
    logic [2*COORD_WIDTH-1:0]  r_sqx, r_sqy;
    logic [SQ_IN_W-1:0]        r_sum;

    // Angle cuts.
    logic signed [ANGD_W-1:0]  w_dax, w_day;
    logic [ANGD_W-1:0]         w_max, w_may;
    logic [1:0]                r_ang_ok;

    // Delay lines to the result stage.
    logic [1:0]              r_ang_dly [D_ANG];
    logic [1:0]              r_off_dly [D_OFF];
    logic [1:0]              r_deg_dly [D_DEG];
    logic signed [COS_W-1:0] r_cos_dly [D_COS];

    // The pipeline moves unless a result waits on a stalled output.
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;
    assign accept  = i_valid && en;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    // Register writes and load items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_z   <= '0;
            r_xoff    <= '0;
            r_yoff    <= '0;
            r_yang    <= '0;
            r_xang    <= '0;
            r_ref_sx  <= '0;
            r_ref_sy  <= '0;
            r_ref_sz  <= '0;
            r_ref_ex  <= '0;
            r_ref_ey  <= '0;
            r_ref_ez  <= '0;
            r_ref_len <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_EXTRAP_Z: r_ext_z <= pwdata[COORD_WIDTH-1:0];
                    REG_X_OFF:    r_xoff  <= pwdata[OLIM_W-1:0];
                    REG_Y_OFF:    r_yoff  <= pwdata[OLIM_W-1:0];
                    REG_Y_ANG:    r_yang  <= pwdata[ALIM_W-1:0];
                    REG_X_ANG:    r_xang  <= pwdata[ALIM_W-1:0];
                    default: ;
                endcase
            end
            if (accept && i_opcode == OP_LOAD) begin
                r_ref_sx  <= i_start_x;
                r_ref_sy  <= i_start_y;
                r_ref_sz  <= i_start_z;
                r_ref_ex  <= i_end_x;
                r_ref_ey  <= i_end_y;
                r_ref_ez  <= i_end_z;
                r_ref_len <= i_track_length;
            end
        end
    end

    // Register reads.
    always_comb begin
        unique case (cfg_idx)
            REG_EXTRAP_Z: prdata = 32'(r_ext_z);
            REG_X_OFF:    prdata = 32'(r_xoff);
            REG_Y_OFF:    prdata = 32'(r_yoff);
            REG_Y_ANG:    prdata = 32'(r_yang);
            REG_X_ANG:    prdata = 32'(r_xang);
            default:      prdata = '0;
        endcase
    end

    // Valid bits travel with the items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[T_RES-2:0], accept && i_opcode == OP_TEST};
            r_out_valid <= r_vld[T_RES-1];
        end
    end

    // Stage 1: deltas, distances to the plane and degenerate flags.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_drx  <= DELTA_W'(r_ref_ex) - DELTA_W'(r_ref_sx);
            r1_dry  <= DELTA_W'(r_ref_ey) - DELTA_W'(r_ref_sy);
            r1_drz  <= DELTA_W'(r_ref_ez) - DELTA_W'(r_ref_sz);
            r1_dcx  <= DELTA_W'(i_end_x) - DELTA_W'(i_start_x);
            r1_dcy  <= DELTA_W'(i_end_y) - DELTA_W'(i_start_y);
            r1_dcz  <= DELTA_W'(i_end_z) - DELTA_W'(i_start_z);
            r1_ezr  <= DELTA_W'(r_ext_z) - DELTA_W'(r_ref_sz);
            r1_ezc  <= DELTA_W'(r_ext_z) - DELTA_W'(i_start_z);
            r1_rsx  <= r_ref_sx;
            r1_rsy  <= r_ref_sy;
            r1_csx  <= i_start_x;
            r1_csy  <= i_start_y;
            r1_lr   <= r_ref_len;
            r1_lc   <= i_track_length;
            r1_zdz  <= (r_ref_ez == r_ref_sz) || (i_end_z == i_start_z);
            r1_zlen <= (r_ref_len == '0) || (i_track_length == '0);
        end
    end

    // Stage 2: numerators of the extrapolation and the dot product terms.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_nrx <= r1_drx * r1_ezr;
            r2_nry <= r1_dry * r1_ezr;
            r2_ncx <= r1_dcx * r1_ezc;
            r2_ncy <= r1_dcy * r1_ezc;
            r2_p0  <= r1_drx * r1_dcx;
            r2_p1  <= r1_dry * r1_dcy;
            r2_p2  <= r1_drz * r1_dcz;
            r2_lp  <= r1_lr * r1_lc;
            r2_dzr <= r1_drz;
            r2_dzc <= r1_dcz;
            r2_rsx <= r1_rsx;
            r2_rsy <= r1_rsy;
            r2_csx <= r1_csx;
            r2_csy <= r1_csy;
        end
    end

    // Stage 3: sum of the dot product.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dot <= DOT_W'(r2_p0) + DOT_W'(r2_p1) + DOT_W'(r2_p2);
            r3_lp  <= r2_lp;
        end
    end

    // Positions of both tracks on the plane.
    tpm_extrap_div u_div_rx (
        .i_clk(i_clk), .i_en(en), .i_num(r2_nrx), .i_dz(r2_dzr), .i_base(r2_rsx),
        .o_pos(w_prx)
    );
    tpm_extrap_div u_div_ry (
        .i_clk(i_clk), .i_en(en), .i_num(r2_nry), .i_dz(r2_dzr), .i_base(r2_rsy),
        .o_pos(w_pry)
    );
    tpm_extrap_div u_div_cx (
        .i_clk(i_clk), .i_en(en), .i_num(r2_ncx), .i_dz(r2_dzc), .i_base(r2_csx),
        .o_pos(w_pcx)
    );
    tpm_extrap_div u_div_cy (
        .i_clk(i_clk), .i_en(en), .i_num(r2_ncy), .i_dz(r2_dzc), .i_base(r2_csy),
        .o_pos(w_pcy)
    );

    // Projected angles of both tracks.
    tpm_atan u_atan_rx (
        .i_clk(i_clk), .i_en(en), .i_num(r1_drx), .i_den(r1_drz), .o_angle(w_arx)
    );
    tpm_atan u_atan_ry (
        .i_clk(i_clk), .i_en(en), .i_num(r1_dry), .i_den(r1_drz), .o_angle(w_ary)
    );
    tpm_atan u_atan_cx (
        .i_clk(i_clk), .i_en(en), .i_num(r1_dcx), .i_den(r1_dcz), .o_angle(w_acx)
    );
    tpm_atan u_atan_cy (
        .i_clk(i_clk), .i_en(en), .i_num(r1_dcy), .i_den(r1_dcz), .o_angle(w_acy)
    );

    // Cosine of the angle between the tracks.
    tpm_cos_div u_cos (
        .i_clk(i_clk), .i_en(en), .i_dot(r3_dot), .i_lp(r3_lp), .o_cos(w_cos)
    );

    // Angle differences against their limits.
    always_comb begin
        w_dax = ANGD_W'(w_arx) - ANGD_W'(w_acx);
        w_day = ANGD_W'(w_ary) - ANGD_W'(w_acy);
        w_max = w_dax[ANGD_W-1] ? ANGD_W'(-w_dax) : ANGD_W'(w_dax);
        w_may = w_day[ANGD_W-1] ? ANGD_W'(-w_day) : ANGD_W'(w_day);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_ok <= {w_may < ANGD_W'(r_yang), w_max < ANGD_W'(r_xang)};
        end
    end

    // Offsets, their magnitudes, squares and sum.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox     <= OFF_W'(w_prx) - OFF_W'(w_pcx);
            r_oy     <= OFF_W'(w_pry) - OFF_W'(w_pcy);
            r_ax     <= r_ox[OFF_W-1] ? OFF_W'(-r_ox) : OFF_W'(r_ox);
            r_ay     <= r_oy[OFF_W-1] ? OFF_W'(-r_oy) : OFF_W'(r_oy);
            r_sat2   <= (r_ox[OFF_W-1] ? OFF_W'(-r_ox) : OFF_W'(r_ox)) > OFF_W'(RES_MAX) ||
                        (r_oy[OFF_W-1] ? OFF_W'(-r_oy) : OFF_W'(r_oy)) > OFF_W'(RES_MAX);
            r_off_ok <= {r_ay < OFF_W'(r_yoff), r_ax < OFF_W'(r_xoff)};
            r_sqx    <= r_ax[COORD_WIDTH-1:0] * r_ax[COORD_WIDTH-1:0];
            r_sqy    <= r_ay[COORD_WIDTH-1:0] * r_ay[COORD_WIDTH-1:0];
            r_sat3   <= r_sat2;
            r_sum    <= SQ_IN_W'(r_sqx) + SQ_IN_W'(r_sqy);
            r_sat4   <= r_sat3;
        end
    end

    tpm_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_val(r_sum), .i_sat(r_sat4), .o_root(w_root)
    );

    // Delay lines that bring the flags and the cosine to the result stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang_dly[0] <= r_ang_ok;
            for (int i = 1; i < D_ANG; i++) begin
                r_ang_dly[i] <= r_ang_dly[i-1];
            end
            r_off_dly[0] <= r_off_ok;
            for (int i = 1; i < D_OFF; i++) begin
                r_off_dly[i] <= r_off_dly[i-1];
            end
            r_deg_dly[0] <= {r1_zlen, r1_zdz};
            for (int i = 1; i < D_DEG; i++) begin
                r_deg_dly[i] <= r_deg_dly[i-1];
            end
            r_cos_dly[0] <= w_cos;
            for (int i = 1; i < D_COS; i++) begin
                r_cos_dly[i] <= r_cos_dly[i-1];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_matched    <= (&r_ang_dly[D_ANG-1]) && (&r_off_dly[D_OFF-1]) &&
                            !(|r_deg_dly[D_DEG-1]);
            o_residual   <= r_deg_dly[D_DEG-1][0] ? '0 : w_root;
            o_cos_angle  <= r_deg_dly[D_DEG-1][1] ? '0 : r_cos_dly[D_COS-1];
            o_degenerate <= |r_deg_dly[D_DEG-1];
        end
    end

    assign o_valid = r_out_valid;

    // A degenerate pair never matches.
    a_deg_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> !o_matched)
        else $error("degenerate item reported as matched");

    // The cosine stays within one.
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cos_angle <= COS_ONE) && (o_cos_angle >= -COS_ONE))
        else $error("cosine out of range");

    // A load item enters no result into the pipeline.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_opcode == OP_LOAD) |=> !r_vld[0])
        else $error("load item produced a result");

    // A held result freezes the valid bits in flight.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for track_pair_match_cut_top: loads reference tracks,
// streams candidate tracks and checks every result against an in-bench predictor.
// Depends on tpm_pkg and track_pair_match_cut_top only.
`timescale 1ns / 1ps

module tb;
    import tpm_pkg::*;

    localparam int CW = COORD_WIDTH;

    // Opcodes and register indexes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;
    localparam int REG_EXTRAP_Z  = 0;
    localparam int REG_X_OFF_LIM = 1;
    localparam int REG_Y_OFF_LIM = 2;
    localparam int REG_Y_ANG_LIM = 3;
    localparam int REG_X_ANG_LIM = 4;
    localparam int REG_UNUSED    = 6;
    localparam int DRAIN_CYCLES  = 90;

    typedef struct {
        logic                 opcode;
        logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
        logic [CW-1:0]        len;
    } track_item_t;

    typedef struct {
        logic                    matched;
        logic [CW-1:0]           residual;
        logic signed [COS_W-1:0] cos_angle;
        logic                    degenerate;
    } match_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_opcode = 1'b0;
    logic signed [CW-1:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [CW-1:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic [CW-1:0] i_track_length = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_matched;
    logic [CW-1:0] o_residual;
    logic signed [COS_W-1:0] o_cos_angle;
    logic o_degenerate;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    track_pair_match_cut_top uut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow registers and reference track held by the predictor.
    longint plane_z, x_off_lim, y_off_lim, y_ang_lim, x_ang_lim;
    longint ref_s[3], ref_e[3], ref_len;

    match_result_t pending_results[$];
    int errors = 0;
    int n_loads = 0, n_tests = 0, n_results = 0, n_matched = 0, n_degen = 0;
    int n_writes = 0;
    bit sender_busy_only = 0;
    int hold_requests = 0, holds_served = 0;

    function automatic longint iabs(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Rounded quotient, half away from zero, magnitude clipped.
    function automatic longint div_round(longint n, longint d, longint sat);
        longint q;
        bit neg;
        neg = (n < 0) != (d < 0);
        q = (iabs(n) + iabs(d) / 2) / iabs(d);
        if (q > sat) q = sat;
        return neg ? -q : q;
    endfunction

    // Projected angle of num/den by rotation steps, in 2^-14 rad.
    function automatic longint slope_angle(longint num, longint den);
        longint x, y, z, xs, ys;
        x = iabs(den) << PRESCALE_BITS;
        y = (den < 0 ? -num : num) << PRESCALE_BITS;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        return (z + (longint'(1) << (ANG_SH - 1))) >>> ANG_SH;
    endfunction

    function automatic longint point_at_plane(longint p1, longint dp, longint z1, longint dz);
        return p1 + div_round(dp * (plane_z - z1), dz, longint'(1) << 60);
    endfunction

    // Square root rounded to nearest.
    function automatic longint root_near(longint n);
        longint lo, hi, mid;
        lo = 0;
        hi = 1 << 21;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n) lo = mid; else hi = mid - 1;
        end
        return (n - lo * lo > lo) ? lo + 1 : lo;
    endfunction

    // Updates the reference on a load and queues the result of a test.
    task automatic predict_match(input track_item_t it);
        longint s[3], e[3], dr[3], dc[3];
        longint ox, oy, resid, cosv, dot, lp;
        bit zdz, zlen, hit;
        match_result_t r;
        s = '{longint'(it.sx), longint'(it.sy), longint'(it.sz)};
        e = '{longint'(it.ex), longint'(it.ey), longint'(it.ez)};
        if (it.opcode == OP_LOAD) begin
            ref_s = s;
            ref_e = e;
            ref_len = longint'(it.len);
            n_loads++;
            return;
        end
        for (int i = 0; i < 3; i++) begin
            dr[i] = ref_e[i] - ref_s[i];
            dc[i] = e[i] - s[i];
        end
        zdz = (dr[2] == 0) || (dc[2] == 0);
        zlen = (ref_len == 0) || (it.len == 0);
        resid = 0;
        cosv = 0;
        hit = 0;
        if (!zdz) begin
            ox = point_at_plane(ref_s[0], dr[0], ref_s[2], dr[2])
               - point_at_plane(s[0], dc[0], s[2], dc[2]);
            oy = point_at_plane(ref_s[1], dr[1], ref_s[2], dr[2])
               - point_at_plane(s[1], dc[1], s[2], dc[2]);
            if (iabs(ox) > longint'(RES_MAX) || iabs(oy) > longint'(RES_MAX))
                resid = longint'(RES_MAX);
            else
                resid = root_near(ox * ox + oy * oy);
            if (resid > longint'(RES_MAX)) resid = longint'(RES_MAX);
            hit = iabs(slope_angle(dr[1], dr[2]) - slope_angle(dc[1], dc[2])) < y_ang_lim
               && iabs(slope_angle(dr[0], dr[2]) - slope_angle(dc[0], dc[2])) < x_ang_lim
               && iabs(ox) < x_off_lim && iabs(oy) < y_off_lim;
        end
        if (!zlen) begin
            dot = dr[0] * dc[0] + dr[1] * dc[1] + dr[2] * dc[2];
            lp = ref_len * longint'(it.len);
            cosv = div_round(dot <<< COS_FRAC, lp, COS_ONE);
        end
        r.matched = hit && !zdz && !zlen;
        r.residual = resid[CW-1:0];
        r.cos_angle = cosv[COS_W-1:0];
        r.degenerate = zdz || zlen;
        pending_results.push_back(r);
        n_tests++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one item and waits until it is taken.
    task automatic send_item(input track_item_t it);
        int gap;
        gap = sender_busy_only ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
        end
        repeat (gap) @(posedge i_clk);
        i_valid <= 1'b1;
        i_opcode <= it.opcode;
        i_start_x <= it.sx; i_start_y <= it.sy; i_start_z <= it.sz;
        i_end_x <= it.ex; i_end_y <= it.ey; i_end_z <= it.ez;
        i_track_length <= it.len;
        do @(posedge i_clk); while (o_stall);
        predict_match(it);
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
    endtask

    task automatic reg_write(input int idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx * 4); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_EXTRAP_Z:  plane_z = longint'($signed(val[CW-1:0]));
            REG_X_OFF_LIM: x_off_lim = longint'(val[OLIM_W-1:0]);
            REG_Y_OFF_LIM: y_off_lim = longint'(val[OLIM_W-1:0]);
            REG_Y_ANG_LIM: y_ang_lim = longint'(val[ALIM_W-1:0]);
            REG_X_ANG_LIM: x_ang_lim = longint'(val[ALIM_W-1:0]);
            default: ;
        endcase
        n_writes++;
    endtask

    // Waits until every result is in and the pipeline is empty.
    task automatic drain();
        stop_sending();
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_cuts(input logic [31:0] z, xo, yo, ya, xa);
        reg_write(REG_EXTRAP_Z, z);
        reg_write(REG_X_OFF_LIM, xo);
        reg_write(REG_Y_OFF_LIM, yo);
        reg_write(REG_Y_ANG_LIM, ya);
        reg_write(REG_X_ANG_LIM, xa);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 11))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return '0;
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic signed [CW-1:0] jitter(logic signed [CW-1:0] v, int amt);
        return v + CW'($signed($urandom_range(0, 2 * amt)) - amt);
    endfunction

    function automatic track_item_t make_track(logic op, int span);
        track_item_t t;
        t.opcode = op;
        t.sx = span == 0 ? rand_coord() : CW'($signed($urandom_range(0, 2 * span)) - span);
        t.sy = span == 0 ? rand_coord() : CW'($signed($urandom_range(0, 2 * span)) - span);
        t.sz = span == 0 ? rand_coord() : CW'($signed($urandom_range(0, 2 * span)) - span);
        t.ex = jitter(t.sx, span == 0 ? 200000 : span);
        t.ey = jitter(t.sy, span == 0 ? 200000 : span);
        t.ez = jitter(t.sz, span == 0 ? 200000 : span);
        if ($urandom_range(0, 29) == 0) t.ez = t.sz;
        t.len = $urandom_range(0, 24) == 0 ? '0 :
                ($urandom_range(0, 9) == 0 ? CW'($urandom) : CW'($urandom_range(1, 4000)));
        return t;
    endfunction

    // Candidate close to the given reference, so that the cuts have a chance.
    function automatic track_item_t near_candidate(track_item_t r, int amt);
        track_item_t t;
        t = r;
        t.opcode = OP_TEST;
        t.sx = jitter(r.sx, amt); t.sy = jitter(r.sy, amt); t.sz = jitter(r.sz, amt);
        t.ex = jitter(r.ex, amt); t.ey = jitter(r.ey, amt); t.ez = jitter(r.ez, amt);
        if ($urandom_range(0, 15) == 0) t.len = CW'($urandom);
        return t;
    endfunction

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        match_result_t x;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result arrived with nothing expected");
                errors++;
            end else begin
                x = pending_results.pop_front();
                if (o_matched !== x.matched) begin
                    $error("matched: expected %0d, got %0d", x.matched, o_matched);
                    errors++;
                end
                if (o_residual !== x.residual) begin
                    $error("residual: expected %0d, got %0d", x.residual, o_residual);
                    errors++;
                end
                if (o_cos_angle !== x.cos_angle) begin
                    $error("cos_angle: expected %0d, got %0d", x.cos_angle, o_cos_angle);
                    errors++;
                end
                if (o_degenerate !== x.degenerate) begin
                    $error("degenerate: expected %0d, got %0d", x.degenerate, o_degenerate);
                    errors++;
                end
                n_matched += x.matched;
                n_degen += x.degenerate;
            end
        end
    end

    // Receiver stalls: random bursts, quiet stretches and the long hold-off.
    int stall_left = 0, quiet_left = 0, hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (holds_served < hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= 400;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (quiet_left > 0) begin
            quiet_left <= quiet_left - 1;
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            quiet_left <= $urandom_range(10, 80);
            i_stall <= 1'b0;
        end else begin
            stall_left <= gap_len();
            i_stall <= 1'b0;
        end
    end

    // Directed cases: no reference yet, extremes, zero dz, zero length, a match.
    task automatic test_directed();
        track_item_t t, r;
        set_cuts(32'd0, 32'h7FFFF, 32'h7FFFF, 32'd25736, 32'd25736);
        t = '{OP_TEST, 20'sd10, 20'sd20, 20'sd0, 20'sd50, 20'sd70, 20'sd100, 20'd100};
        send_item(t);
        r = '{OP_LOAD, 20'sd0, 20'sd0, 20'sd0, 20'sd64, 20'sd64, 20'sd640, 20'd646};
        send_item(r);
        t = r; t.opcode = OP_TEST;
        send_item(t);
        t.ex = 20'sd70; send_item(t);
        t.ez = t.sz; send_item(t);
        t = r; t.opcode = OP_TEST; t.len = '0; send_item(t);
        t = r; t.opcode = OP_TEST; t.ex = -20'sd64; t.ey = -20'sd64; t.ez = -20'sd640;
        send_item(t);
        // Extreme coordinates: saturating residual and full-range deltas.
        t = '{OP_TEST, -20'sd524288, -20'sd524288, -20'sd524288,
              20'sd524287, 20'sd524287, -20'sd524287, 20'hFFFFF};
        send_item(t);
        r = '{OP_LOAD, 20'sd524287, -20'sd524288, 20'sd524287,
              -20'sd524288, 20'sd524287, -20'sd524288, 20'hFFFFF};
        send_item(r);
        send_item(t);
        t = r; t.opcode = OP_TEST; send_item(t);
        t.sz = 20'sd524286; send_item(t);
        t.len = 20'd1; send_item(t);
        // Zero-length reference.
        r = '{OP_LOAD, 20'sd5, 20'sd5, 20'sd5, 20'sd6, 20'sd5, 20'sd9, 20'd0};
        send_item(r);
        t = r; t.opcode = OP_TEST; t.len = 20'd4; send_item(t);
        // Zero-dz reference.
        r = '{OP_LOAD, 20'sd5, 20'sd5, 20'sd5, 20'sd6, 20'sd5, 20'sd5, 20'd1};
        send_item(r);
        t.len = 20'd4; send_item(t);
        drain();
        // Far plane and the tightest cuts.
        set_cuts(32'hFFF80000, 32'd0, 32'd0, 32'd0, 32'd0);
        r = '{OP_LOAD, 20'sd0, 20'sd0, 20'sd0, 20'sd64, 20'sd64, 20'sd640, 20'd646};
        send_item(r);
        t = r; t.opcode = OP_TEST; send_item(t);
        drain();
        set_cuts(32'h0007FFFF, 32'd1, 32'd1, 32'd1, 32'd1);
        send_item(t);
        t.ex = 20'sd65; send_item(t);
        drain();
    endtask

    // Random phases, each with its own plane and cut settings.
    task automatic test_random_phases();
        track_item_t r, t;
        int sent, per_phase, span, amt;
        logic [31:0] w;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_cuts(32'h00080000, 32'h7FFFF, 32'h7FFFF, 32'h7FFF, 32'h7FFF);
                1: set_cuts(32'h0007FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
                default: begin
                    // Whole 32-bit words now and then: only the low bits count.
                    for (int k = REG_EXTRAP_Z; k <= REG_X_ANG_LIM; k++) begin
                        w = $urandom_range(0, 3) == 0 ? $urandom :
                            (k == REG_EXTRAP_Z ? 32'($signed($urandom_range(0, 4000)) - 2000)
                             : (k >= REG_Y_ANG_LIM ? $urandom_range(0, 2000)
                                                    : $urandom_range(0, 600)));
                        reg_write(k, w);
                    end
                    reg_write(REG_UNUSED, $urandom);
                end
            endcase
            sender_busy_only = (ph == 3);
            per_phase = 200;
            sent = 0;
            while (sent < per_phase) begin
                span = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(50, 3000);
                r = make_track(OP_LOAD, span);
                if ($urandom_range(0, 19) == 0) r.opcode = OP_TEST;
                send_item(r);
                sent++;
                repeat ($urandom_range(1, 8)) begin
                    amt = $urandom_range(0, 3) == 0 ? $urandom_range(20, 500)
                                                    : $urandom_range(0, 6);
                    t = $urandom_range(0, 9) == 0 ? make_track(OP_TEST, span)
                                                  : near_candidate(r, amt);
                    send_item(t);
                    sent++;
                end
            end
            sender_busy_only = 0;
            drain();
        end
    endtask

    // Long receiver hold-off while items keep coming: the pipeline fills up.
    task automatic test_backpressure();
        track_item_t r;
        set_cuts(32'd100, 32'd300, 32'd300, 32'd800, 32'd800);
        sender_busy_only = 1;
        hold_requests++;
        r = make_track(OP_LOAD, 1000);
        send_item(r);
        repeat (150) send_item(near_candidate(r, 3));
        sender_busy_only = 0;
        drain();
    endtask

    initial begin
        plane_z = 0; x_off_lim = 0; y_off_lim = 0; y_ang_lim = 0; x_ang_lim = 0;
        ref_s = '{0, 0, 0}; ref_e = '{0, 0, 0}; ref_len = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_phases();
        drain();
        $display("Covered %0d loads and %0d tests (%0d matched, %0d degenerate).",
                 n_loads, n_tests, n_matched, n_degen);
        $display("Checked %0d results over %0d register writes.", n_results, n_writes);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
